>>> design/prefix_match_comparison_count_top_defines.svh
// Assertion macros shared by the prefix match comparison counter.
`ifndef PREFIX_MATCH_COMPARISON_COUNT_TOP_DEFINES_SVH
`define PREFIX_MATCH_COMPARISON_COUNT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define PMCC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pmcc assertion failed");
// Check that a condition never holds outside reset.
`define PMCC_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pmcc forbidden condition seen");
`else
`define PMCC_ASSERT(name, clk, rstn, prop)
`define PMCC_NEVER(name, clk, rstn, cond)
`endif

`endif

>>> design/pmcc_pkg.sv
// Shared types and constants of the prefix match comparison counter.
package pmcc_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned TOTAL_W = 19;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Fill status of the job queue.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Memory write port from the loader to the compare engine.
  typedef struct packed {
    logic              en;
    logic [CHAR_W-1:0] data;
  } wr_ctrl_t;

endpackage

>>> design/prefix_match_comparison_count_top.sv
// Characters load one per cycle while busy_o is low; the result strobe follows
// the last character once the C comparisons are made (at most len*(len-1)/2),
// each comparison being one S_READ and one S_CMP state on the dual-read text
// memory. busy_o stays high through the result cycle.
// Reset is asynchronous, active low, and clears control state; the text memory
// is not cleared. The result strobe cannot be stalled by the receiver.
module prefix_match_comparison_count_top #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [pmcc_pkg::CHAR_W-1:0]  char_in_i,
  input  logic                         last_i,
  output logic                         done_o,
  output logic [pmcc_pkg::TOTAL_W-1:0] total_o,
  output logic                         overflow_o
);
  import pmcc_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  q_status_t         q_status;
  wr_ctrl_t          wr;
  logic [ADDR_W-1:0] wr_addr;
  logic              push, pop, back_busy;
  logic [LEN_W:0]    job_in, job_out;

  // Load characters and issue jobs.
  pmcc_front #(
    .MAX_LEN (MAX_LEN),
    .LEN_W   (LEN_W),
    .ADDR_W  (ADDR_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .char_in_i   (char_in_i),
    .last_i      (last_i),
    .back_busy_i (back_busy),
    .q_status_i  (q_status),
    .busy_o      (busy_o),
    .wr_o        (wr),
    .wr_addr_o   (wr_addr),
    .push_o      (push),
    .job_o       (job_in)
  );

  // Hold jobs between loader and engine.
  pmcc_queue #(
    .W (LEN_W + 1)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (job_in),
    .pop_i    (pop),
    .data_o   (job_out),
    .status_o (q_status)
  );

  // Count comparisons and deliver the total.
  pmcc_back #(
    .MAX_LEN (MAX_LEN),
    .LEN_W   (LEN_W),
    .ADDR_W  (ADDR_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .wr_addr_i  (wr_addr),
    .q_status_i (q_status),
    .job_i      (job_out),
    .pop_o      (pop),
    .busy_o     (back_busy),
    .done_o     (done_o),
    .total_o    (total_o),
    .overflow_o (overflow_o)
  );

endmodule

>>> design/pmcc_front.sv
// Loader: accepts characters, writes them to the text memory, issues jobs.
module pmcc_front #(
  parameter int unsigned MAX_LEN = 1024,
  parameter int unsigned LEN_W   = $clog2(MAX_LEN + 1),
  parameter int unsigned ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pmcc_pkg::CHAR_W-1:0]  char_in_i,
  input  logic                         last_i,
  input  logic                         back_busy_i,
  input  pmcc_pkg::q_status_t          q_status_i,
  output logic                         busy_o,
  output pmcc_pkg::wr_ctrl_t           wr_o,
  output logic [ADDR_W-1:0]            wr_addr_o,
  output logic                         push_o,
  output logic [LEN_W:0]               job_o
);
  import pmcc_pkg::*;

  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             accept;
  logic             room;

  // Stall while a string is still being counted: the memory is shared.
  assign busy_o = !q_status_i.empty || back_busy_i || q_status_i.full;
  assign accept = start_i && !busy_o;
  assign room   = (len_q < LEN_W'(MAX_LEN));

  // Store the character when there is space, drop it otherwise.
  assign wr_o.en    = accept && room;
  assign wr_o.data  = char_in_i;
  assign wr_addr_o  = len_q[ADDR_W-1:0];

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    push_o = 1'b0;
    job_o  = {ovf_q, len_q};
    if (accept) begin
      if (room) begin
        len_d = len_q + LEN_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (last_i) begin
        push_o = 1'b1;
        job_o  = {ovf_d, len_d};
        len_d  = '0;
        ovf_d  = 1'b0;
      end
    end
  end

  // Hold length and overflow of the string being loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

>>> design/pmcc_queue.sv
// Two-entry job queue between loader and compare engine.
module pmcc_queue #(
  parameter int unsigned W = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [W-1:0]        data_i,
  input  logic                pop_i,
  output logic [W-1:0]        data_o,
  output pmcc_pkg::q_status_t status_o
);
  import pmcc_pkg::*;

  logic [W-1:0] entry_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign status_o.empty = (cnt_q == 2'd0);
  assign status_o.full  = (cnt_q == 2'd2);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = entry_q[rd_ptr_q];

  // Store the pushed job.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> design/pmcc_back.sv
// Compare engine: text memory and the naive prefix match comparison count.
`include "prefix_match_comparison_count_top_defines.svh"
module pmcc_back #(
  parameter int unsigned MAX_LEN = 1024,
  parameter int unsigned LEN_W   = $clog2(MAX_LEN + 1),
  parameter int unsigned ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pmcc_pkg::wr_ctrl_t            wr_i,
  input  logic [ADDR_W-1:0]             wr_addr_i,
  input  pmcc_pkg::q_status_t           q_status_i,
  input  logic [LEN_W:0]                job_i,
  output logic                          pop_o,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [pmcc_pkg::TOTAL_W-1:0]  total_o,
  output logic                          overflow_o
);
  import pmcc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [LEN_W-1:0] len_q, i_q, z_q;
  logic             ovf_q;
  logic [TOTAL_W-1:0] sum_q;
  logic [CHAR_W-1:0]  mem [MAX_LEN];
  logic [CHAR_W-1:0]  ra_q, rb_q;
  logic [ADDR_W-1:0]  addr_a, addr_b;
  logic [LEN_W-1:0]   i_next, z_reach;
  logic [TOTAL_W-1:0] sum_inc;

  assign pop_o   = (state_q == S_IDLE) && !q_status_i.empty;
  assign busy_o  = (state_q != S_IDLE);
  assign addr_a  = z_q[ADDR_W-1:0];
  assign addr_b  = ADDR_W'(i_q + z_q);
  assign i_next  = i_q + LEN_W'(1);
  assign z_reach = i_q + z_q + LEN_W'(1);
  assign sum_inc = (sum_q == TOTAL_MAX) ? sum_q : sum_q + TOTAL_W'(1);

  assign done_o     = (state_q == S_DONE);
  assign total_o    = sum_q;
  assign overflow_o = ovf_q;

  // Write loaded characters, read prefix and shifted character.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr_i] <= wr_i.data;
    end
    if (state_q == S_READ) begin
      ra_q <= mem[addr_a];
      rb_q <= mem[addr_b];
    end
  end

  // Step through start positions, one comparison per read and compare pair.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      i_q     <= '0;
      z_q     <= '0;
      ovf_q   <= 1'b0;
      sum_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (!q_status_i.empty) begin
            len_q <= job_i[LEN_W-1:0];
            ovf_q <= job_i[LEN_W];
            sum_q <= '0;
            i_q   <= LEN_W'(1);
            z_q   <= '0;
            if (job_i[LEN_W-1:0] < LEN_W'(2)) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          sum_q <= sum_inc;
          if ((ra_q == rb_q) && (z_reach < len_q)) begin
            z_q     <= z_q + LEN_W'(1);
            state_q <= S_READ;
          end else if (i_next == len_q) begin
            state_q <= S_DONE;
          end else begin
            i_q     <= i_next;
            z_q     <= '0;
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PMCC_ASSERT(a_done_one_cycle, clk_i, rst_ni, done_o |=> !done_o)
  `PMCC_NEVER(a_start_in_range, clk_i, rst_ni,
              (state_q == S_READ || state_q == S_CMP) && (i_q >= len_q))
  `PMCC_ASSERT(a_read_then_cmp, clk_i, rst_ni, (state_q == S_READ) |=> (state_q == S_CMP))
  `PMCC_NEVER(a_no_write_while_busy, clk_i, rst_ni, wr_i.en && busy_o)

endmodule
